// ===== src/mcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	localparam int DEC_BITS   = 16;
	localparam int OCT_POINTS = 8;
	localparam int PT_BITS    = 3;

	localparam logic [PT_BITS-1:0] PT_LAST = PT_BITS'(OCT_POINTS - 1);

	localparam logic signed [DEC_BITS-1:0] DEC_INIT   = 16'sd3;
	localparam logic signed [DEC_BITS-1:0] DEC_DIAG   = 16'sd10;
	localparam logic signed [DEC_BITS-1:0] DEC_STRAIT = 16'sd6;

endpackage

`default_nettype wire

// ===== src/mcr_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_fifo
// Small register queue between the step unit and the point emitter.
// ----------------------------------------------------------------------------
module mcr_fifo #(
	parameter int WIDTH = 51,
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rd_data,
	output logic                            full,
	output logic                            nonempty,
	output logic [$clog2(DEPTH+1)-1:0]      level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign level    = count_q;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/mcr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_front
// Takes start and advance items and keeps the circle state; a start, or an
// active advance (one decision-variable step), queues one octet descriptor.
// ----------------------------------------------------------------------------
module mcr_front
	import mcr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          operation,
	input  wire logic signed [COORD_BITS-1:0]  center_x,
	input  wire logic signed [COORD_BITS-1:0]  center_y,
	input  wire logic [COORD_BITS-2:0]         radius,
	output logic                               push,
	output logic [4*COORD_BITS+2:0]            push_data
);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ox;
		logic signed [COORD_BITS-1:0] oy;
		logic signed [COORD_BITS:0]   sx;
		logic signed [COORD_BITS:0]   sy;
		logic                         done;
	} desc_t;

	localparam logic signed [COORD_BITS:0] ONE = 1;

	logic signed [COORD_BITS-1:0] origin_x_q;
	logic signed [COORD_BITS-1:0] origin_y_q;
	logic signed [COORD_BITS:0]   step_x_q;
	logic signed [COORD_BITS:0]   step_y_q;
	logic signed [DEC_BITS-1:0]   decision_q;
	logic                         active_q;

	logic                         is_start;
	logic                         dec_pos;
	logic signed [COORD_BITS:0]   x_new;
	logic signed [COORD_BITS:0]   y_new;
	logic signed [COORD_BITS:0]   diff;
	logic signed [DEC_BITS-1:0]   dec_term;
	logic signed [DEC_BITS-1:0]   dec_new;
	logic signed [DEC_BITS-1:0]   r_dec;
	logic signed [DEC_BITS-1:0]   dec_init;
	logic signed [COORD_BITS:0]   r_step;
	logic                         done_new;
	desc_t                        desc;

	assign is_start = (op_t'(operation) == OP_START);

	always_comb begin
		dec_pos  = (decision_q > 0);
		x_new    = step_x_q + ONE;
		y_new    = dec_pos ? step_y_q - ONE : step_y_q;
		diff     = x_new - y_new;
		dec_term = dec_pos ? (DEC_BITS'(diff) <<< 2) + DEC_DIAG
		                   : (DEC_BITS'(x_new) <<< 2) + DEC_STRAIT;
		dec_new  = decision_q + dec_term;
		done_new = (y_new < x_new);
		r_dec    = signed'(DEC_BITS'(radius));
		dec_init = DEC_INIT - (r_dec <<< 1);
		r_step   = signed'({2'b00, radius});
	end

	always_comb begin
		if (is_start) begin
			desc.ox   = center_x;
			desc.oy   = center_y;
			desc.sx   = '0;
			desc.sy   = r_step;
			desc.done = 1'b0;
		end else begin
			desc.ox   = origin_x_q;
			desc.oy   = origin_y_q;
			desc.sx   = x_new;
			desc.sy   = y_new;
			desc.done = done_new;
		end
	end

	assign push      = accept && (is_start || active_q);
	assign push_data = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				origin_x_q <= center_x;
				origin_y_q <= center_y;
				step_x_q   <= '0;
				step_y_q   <= r_step;
				decision_q <= dec_init;
				active_q   <= 1'b1;
			end else if (active_q) begin
				step_x_q   <= x_new;
				step_y_q   <= y_new;
				decision_q <= dec_new;
				active_q   <= !done_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/mcr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_back
// Walks one queued octet, producing its eight symmetric points one per cycle
// into a registered output stage while that stage is not stalled.
// ----------------------------------------------------------------------------
module mcr_back
	import mcr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_nonempty,
	input  wire logic [4*COORD_BITS+2:0]     q_data,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [COORD_BITS:0]       point_x,
	output logic signed [COORD_BITS:0]       point_y,
	output logic                             last_of_step,
	output logic                             circle_done
);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ox;
		logic signed [COORD_BITS-1:0] oy;
		logic signed [COORD_BITS:0]   sx;
		logic signed [COORD_BITS:0]   sy;
		logic                         done;
	} desc_t;

	localparam int SW = COORD_BITS + 2;

	desc_t                  desc_q;
	logic [PT_BITS-1:0]     idx_q;
	logic                   busy_q;
	logic                   valid_q;
	logic                   out_free;
	logic                   emit_last;

	logic signed [COORD_BITS:0] a;
	logic signed [COORD_BITS:0] b;
	logic signed [SW-1:0]       px;
	logic signed [SW-1:0]       py;

	assign out_free  = !valid_q || out_ready;
	assign emit_last = busy_q && out_free && (idx_q == PT_LAST);
	assign q_pop     = q_nonempty && (!busy_q || emit_last);
	assign out_valid = valid_q;

	// idx bit 2 swaps x and y, bit 0 negates the x term, bit 1 the y term
	always_comb begin
		a  = idx_q[2] ? desc_q.sy : desc_q.sx;
		b  = idx_q[2] ? desc_q.sx : desc_q.sy;
		px = SW'(desc_q.ox) + (idx_q[0] ? -SW'(a) : SW'(a));
		py = SW'(desc_q.oy) + (idx_q[1] ? -SW'(b) : SW'(b));
	end

	always_ff @(posedge clk) begin
		if (busy_q && out_free) begin
			point_x      <= px[COORD_BITS:0];
			point_y      <= py[COORD_BITS:0];
			last_of_step <= (idx_q == PT_LAST);
			circle_done  <= desc_q.done;
		end
		if (q_pop) begin
			desc_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit_last) begin
				busy_q <= 1'b0;
			end else if (busy_q && out_free) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/midpoint_circle_rasterizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle rasterizer with eight-way symmetry, one point per transfer.
// ----------------------------------------------------------------------------
// A start item loads centre and radius and yields the first octet; each
// advance item takes one decision step and yields the next octet, the final
// one flagged circle_done. An advance with no circle in progress yields
// nothing. Every octet yields eight points on the output, one per cycle
// while out_ready does not stall them; the point emitter sets the sustained
// rate. The step unit takes one item per cycle into a two-entry queue while
// it is not full, so items are taken while earlier octets still drain.
module midpoint_circle_rasterizer
	import mcr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          operation,
	input  wire logic signed [COORD_BITS-1:0]  center_x,
	input  wire logic signed [COORD_BITS-1:0]  center_y,
	input  wire logic [COORD_BITS-2:0]         radius,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_BITS:0]         point_x,
	output logic signed [COORD_BITS:0]         point_y,
	output logic                               last_of_step,
	output logic                               circle_done
);

	localparam int DW    = 4 * COORD_BITS + 3;
	localparam int QDEPTH = 2;
	localparam int LW    = $clog2(QDEPTH + 1);

	logic          accept;
	logic          push;
	logic [DW-1:0] push_data;
	logic          q_full;
	logic          q_nonempty;
	logic          q_pop;
	logic [DW-1:0] q_data;
	logic [LW-1:0] q_level;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	mcr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.push      (push),
		.push_data (push_data)
	);

	mcr_fifo #(
		.WIDTH(DW),
		.DEPTH(QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (push_data),
		.pop      (q_pop),
		.rd_data  (q_data),
		.full     (q_full),
		.nonempty (q_nonempty),
		.level    (q_level)
	);

	mcr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= LW'(QDEPTH))
		else $error("queue level beyond depth");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (q_level == LW'(QDEPTH)))
		else $error("input stalled with room in queue");

	a_start_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_t'(operation) == OP_START)) |=> (q_level != '0))
		else $error("start transfer did not reach the queue");

endmodule

`default_nettype wire
